@@ rtl/frg_pkg.sv @@
// Shared constants and types for the fraction reduction block.
package frg_pkg;

   localparam int DATA_W = 32;
   localparam int DEN_W  = 31;
   localparam int CNT_W  = $clog2(DATA_W);

   localparam logic [DATA_W-1:0] MAG_LIMIT = {1'b0, {(DATA_W-1){1'b1}}};

   typedef struct packed {
      logic [DATA_W-1:0] quot;
      logic [DATA_W-1:0] remainder;
   } div_res_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_cmd_type;

   typedef enum logic [7:0] {
      ST_IDLE       = 8'b0000_0001,
      ST_GCD_ISSUE  = 8'b0000_0010,
      ST_GCD_WAIT   = 8'b0000_0100,
      ST_DIVN_ISSUE = 8'b0000_1000,
      ST_DIVN_WAIT  = 8'b0001_0000,
      ST_DIVD_ISSUE = 8'b0010_0000,
      ST_DIVD_WAIT  = 8'b0100_0000,
      ST_OUT        = 8'b1000_0000
   } state_type;

endpackage

@@ rtl/frg_req_if.sv @@
// Input channel carrying the fraction to reduce.
interface frg_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [frg_pkg::DATA_W-1:0] num_in;
   logic signed [frg_pkg::DATA_W-1:0] den_in;

   modport source (output valid, output num_in, output den_in, input ready);
   modport sink   (input valid, input num_in, input den_in, output ready);
endinterface

@@ rtl/frg_rsp_if.sv @@
// Result channel carrying the reduced fraction and the error flag.
interface frg_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [frg_pkg::DATA_W-1:0] num_out;
   logic        [frg_pkg::DEN_W-1:0]  den_out;
   logic                              zero_den_error;

   modport source (output valid, output num_out, output den_out, output zero_den_error,
                   input ready);
   modport sink   (input valid, input num_out, input den_out, input zero_den_error,
                   output ready);
endinterface

@@ rtl/frg_div.sv @@
// Restoring unsigned divider that produces one quotient bit per cycle.
module frg_div (
   input  logic                 clock,
   input  logic                 reset,
   input  frg_pkg::div_cmd_type cmd,
   output logic                 done,
   output frg_pkg::div_res_type res
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [frg_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [frg_pkg::DATA_W-1:0]  quot_ff, quot_in;
   logic [frg_pkg::DATA_W-1:0]  rem_ff, rem_in;
   logic [frg_pkg::DATA_W-1:0]  divisor_ff, divisor_in;
   logic [frg_pkg::DATA_W:0]    shifted;
   logic [frg_pkg::DATA_W:0]    diff;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      shifted    = {rem_ff, quot_ff[frg_pkg::DATA_W-1]};
      diff       = shifted - {1'b0, divisor_ff};
      if (cmd.start) begin
         busy_in    = 1'b1;
         count_in   = frg_pkg::CNT_W'(frg_pkg::DATA_W - 1);
         quot_in    = cmd.dividend;
         rem_in     = '0;
         divisor_in = cmd.divisor;
      end else if (busy_ff) begin
         if (!diff[frg_pkg::DATA_W]) begin
            rem_in = diff[frg_pkg::DATA_W-1:0];
         end else begin
            rem_in = shifted[frg_pkg::DATA_W-1:0];
         end
         quot_in  = {quot_ff[frg_pkg::DATA_W-2:0], ~diff[frg_pkg::DATA_W]};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done          = done_ff;
   assign res.quot      = quot_ff;
   assign res.remainder = rem_ff;

`ifndef SYNTH
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("Divider started while busy.");
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < divisor_ff))
      else $error("Divider remainder not below divisor.");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("Divider done without a running division.");
`endif

endmodule

@@ rtl/fraction_reduce_gcd.sv @@
// Fraction reduction: Euclidean GCD and two divisions on one shared serial divider.
// A zero numerator or denominator goes straight to the output state; otherwise the result
// follows the Euclidean remainder steps and then the two divisions, all run in turn on the
// shared divider. One item at a time; the next item can be taken in the cycle after a result
// is loaded.
// Reset is synchronous and active high; it clears the sequencer and the result valid.
module fraction_reduce_gcd (
   input logic        clock,
   input logic        reset,
   frg_req_if.sink    req_ch,
   frg_rsp_if.source  rsp_ch
);

   frg_pkg::state_type          state_ff, state_in;
   logic [frg_pkg::DATA_W-1:0]  a_ff, a_in;
   logic [frg_pkg::DATA_W-1:0]  b_ff, b_in;
   logic [frg_pkg::DATA_W-1:0]  nmag_ff, nmag_in;
   logic [frg_pkg::DATA_W-1:0]  dmag_ff, dmag_in;
   logic                        neg_ff, neg_in;
   logic [frg_pkg::DATA_W-1:0]  num_res_ff, num_res_in;
   logic [frg_pkg::DEN_W-1:0]   den_res_ff, den_res_in;
   logic                        err_res_ff, err_res_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [frg_pkg::DATA_W-1:0]  num_out_ff, num_out_in;
   logic [frg_pkg::DEN_W-1:0]   den_out_ff, den_out_in;
   logic                        err_out_ff, err_out_in;
   logic                        load_out;
   logic [frg_pkg::DATA_W-1:0]  n_raw, d_raw;
   logic [frg_pkg::DATA_W-1:0]  n_sat, d_sat;
   frg_pkg::div_cmd_type        div_cmd;
   frg_pkg::div_res_type        div_res;
   logic                        div_done;

   frg_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .done  (div_done),
      .res   (div_res)
   );

   assign n_raw = req_ch.num_in;
   assign d_raw = req_ch.den_in;
   assign n_sat = (nmag_ff > frg_pkg::MAG_LIMIT) ? frg_pkg::MAG_LIMIT : nmag_ff;
   assign d_sat = (div_res.quot > frg_pkg::MAG_LIMIT) ? frg_pkg::MAG_LIMIT : div_res.quot;

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      nmag_in      = nmag_ff;
      dmag_in      = dmag_ff;
      neg_in       = neg_ff;
      num_res_in   = num_res_ff;
      den_res_in   = den_res_ff;
      err_res_in   = err_res_ff;
      load_out     = 1'b0;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = dmag_ff;
      div_cmd.divisor  = a_ff;
      case (state_ff)
         frg_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               num_res_in = '0;
               den_res_in = frg_pkg::DEN_W'(1);
               err_res_in = 1'b0;
               if (n_raw == '0) begin
                  state_in = frg_pkg::ST_OUT;
               end else if (d_raw == '0) begin
                  err_res_in = 1'b1;
                  state_in   = frg_pkg::ST_OUT;
               end else begin
                  neg_in   = n_raw[frg_pkg::DATA_W-1] ^ d_raw[frg_pkg::DATA_W-1];
                  nmag_in  = n_raw[frg_pkg::DATA_W-1] ? (~n_raw + 1'b1) : n_raw;
                  dmag_in  = d_raw[frg_pkg::DATA_W-1] ? (~d_raw + 1'b1) : d_raw;
                  a_in     = nmag_in;
                  b_in     = dmag_in;
                  state_in = frg_pkg::ST_GCD_ISSUE;
               end
            end
         end
         frg_pkg::ST_GCD_ISSUE: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = a_ff;
            div_cmd.divisor  = b_ff;
            state_in         = frg_pkg::ST_GCD_WAIT;
         end
         frg_pkg::ST_GCD_WAIT: begin
            if (div_done) begin
               a_in = b_ff;
               b_in = div_res.remainder;
               if (div_res.remainder == '0) begin
                  state_in = frg_pkg::ST_DIVN_ISSUE;
               end else begin
                  state_in = frg_pkg::ST_GCD_ISSUE;
               end
            end
         end
         frg_pkg::ST_DIVN_ISSUE: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = nmag_ff;
            state_in         = frg_pkg::ST_DIVN_WAIT;
         end
         frg_pkg::ST_DIVN_WAIT: begin
            if (div_done) begin
               nmag_in  = div_res.quot;
               state_in = frg_pkg::ST_DIVD_ISSUE;
            end
         end
         frg_pkg::ST_DIVD_ISSUE: begin
            div_cmd.start = 1'b1;
            state_in      = frg_pkg::ST_DIVD_WAIT;
         end
         frg_pkg::ST_DIVD_WAIT: begin
            if (div_done) begin
               num_res_in = neg_ff ? (~n_sat + 1'b1) : n_sat;
               den_res_in = d_sat[frg_pkg::DEN_W-1:0];
               err_res_in = 1'b0;
               state_in   = frg_pkg::ST_OUT;
            end
         end
         frg_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_out = 1'b1;
               state_in = frg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = frg_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      num_out_in   = num_out_ff;
      den_out_in   = den_out_ff;
      err_out_in   = err_out_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         num_out_in   = num_res_ff;
         den_out_in   = den_res_ff;
         err_out_in   = err_res_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff       <= a_in;
      b_ff       <= b_in;
      nmag_ff    <= nmag_in;
      dmag_ff    <= dmag_in;
      neg_ff     <= neg_in;
      num_res_ff <= num_res_in;
      den_res_ff <= den_res_in;
      err_res_ff <= err_res_in;
      num_out_ff <= num_out_in;
      den_out_ff <= den_out_in;
      err_out_ff <= err_out_in;
   end

   assign req_ch.ready          = (state_ff == frg_pkg::ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.num_out        = num_out_ff;
   assign rsp_ch.den_out        = den_out_ff;
   assign rsp_ch.zero_den_error = err_out_ff;

`ifndef SYNTH
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("Sequencer stayed ready after taking an item.");
   a_den_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (den_out_ff != '0))
      else $error("Result denominator is zero.");
   a_error_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && err_out_ff) |-> (num_out_ff == '0 && den_out_ff == frg_pkg::DEN_W'(1)))
      else $error("Error result is not 0/1.");
   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == frg_pkg::ST_GCD_WAIT || state_ff == frg_pkg::ST_DIVN_WAIT
                    || state_ff == frg_pkg::ST_DIVD_WAIT))
      else $error("Divider finished outside a wait state.");
`endif

endmodule
